// ===== rtl/core/relemb_pkg.sv =====
// ----------------------------------------------------------------------------
// relemb_pkg
// Shared types, constants and helper functions of the relief emboss filter.
// ----------------------------------------------------------------------------
package relemb_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_STRENGTH     = 2'd2
  } cfg_reg_t;

  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;
  localparam int unsigned RESET_STRENGTH = 1;

  // Defaults for the frame store size and the largest size that the
  // position fields of a job can carry.
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned DIM_LIMIT      = 8192;
  localparam int unsigned POS_W          = $clog2(DIM_LIMIT);

  localparam int unsigned OUT_POS_W = 11;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIX_W     = 3 * CHAN_W;

  localparam int unsigned JOB_QUEUE_DEPTH = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic              frame_start;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] out_col;
    logic [OUT_POS_W-1:0] out_row;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic                 last_of_run;
    logic                 frame_end;
  } out_word_t;

  // One classified pixel, handed from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [POS_W-1:0] col;
    logic [1:0]       wr_slot;
    logic [POS_W-1:0] x0;
    logic [1:0]       nx;
    logic [POS_W-1:0] y0;
    logic [1:0]       ny;
    logic [1:0]       y0_slot;
  } job_t;

  function automatic logic [1:0] slot_inc(logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W:0] clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    logic [POS_W:0] r;
    if (v < CFG_DATA_W'(3)) begin
      r = (POS_W+1)'(3);
    end else if (32'(v) > hi) begin
      r = (POS_W+1)'(hi);
    end else begin
      r = (POS_W+1)'(v);
    end
    return r;
  endfunction

  // Centre plus bias minus offset, limited to the channel range. The sum
  // never exceeds 510, so bit 9 set can only mean a negative result.
  function automatic logic [CHAN_W-1:0] relief_chan(logic [CHAN_W-1:0] c,
                                                    logic [CHAN_W-1:0] o,
                                                    logic [CHAN_W-1:0] b);
    logic [9:0]        s;
    logic [CHAN_W-1:0] r;
    s = {2'b00, c} + {2'b00, b} - {2'b00, o};
    if (s[9]) begin
      r = '0;
    end else if (s[8]) begin
      r = '1;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/relief_emboss_filter.sv =====
// Relief emboss filter. Takes RGB pixels in raster order, one word per clock
// while in_ready is high, and returns a relief word for every interior
// position (column 1..W-2, row 1..H-2): each channel is centre + strength/2
// minus the pixel two right and two down (clamped to the last column and
// row), limited to 0..255. A result leaves once its offset pixel has arrived.
// Most pixels cause at most one result; one in the last column or last row
// can cause two, and the last pixel of a frame up to four, whose centres the
// back end reads one after another, since the line store has a single read
// port. A short queue in front of the back end absorbs these bursts. Results
// pass through the job queue, the line store's registered read and the output
// queue. The line store needs no clearing after reset. Configuration must be
// written only while the filter is idle; the filter does not enforce this.
// ----------------------------------------------------------------------------
// relief_emboss_filter
// Top level: configuration registers, front end, job queue, back end and
// output queue.
// ----------------------------------------------------------------------------
module relief_emboss_filter #(
  parameter int unsigned MAX_WIDTH  = relemb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = relemb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  relemb_pkg::in_word_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output relemb_pkg::out_word_t             out_data,
  input  logic                              cfg_wr_en,
  input  logic [relemb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [relemb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT+1);
  localparam int unsigned OLW = $clog2(relemb_pkg::OUT_QUEUE_DEPTH+1);
  localparam int unsigned JLW = $clog2(relemb_pkg::JOB_QUEUE_DEPTH+1);
  localparam int unsigned CDW = relemb_pkg::CFG_DATA_W;

  localparam logic [WW-1:0] W_INIT =
    WW'(relemb_pkg::clamp_size(CDW'(relemb_pkg::RESET_WIDTH), MAX_WIDTH));
  localparam logic [HW-1:0] H_INIT =
    HW'(relemb_pkg::clamp_size(CDW'(relemb_pkg::RESET_HEIGHT), MAX_HEIGHT));
  localparam logic [relemb_pkg::CHAN_W-1:0] BIAS_INIT =
    relemb_pkg::CHAN_W'(relemb_pkg::RESET_STRENGTH >> 1);

  logic [WW-1:0]                 frame_w_r;
  logic [HW-1:0]                 frame_h_r;
  logic [relemb_pkg::CHAN_W-1:0] bias_r;

  // Sizes are held already limited to the legal range; strength is kept
  // only as its half, which is all the datapath uses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= W_INIT;
      frame_h_r <= H_INIT;
      bias_r    <= BIAS_INIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        relemb_pkg::CFG_FRAME_WIDTH: begin
          frame_w_r <= WW'(relemb_pkg::clamp_size(cfg_wdata, MAX_WIDTH));
        end
        relemb_pkg::CFG_FRAME_HEIGHT: begin
          frame_h_r <= HW'(relemb_pkg::clamp_size(cfg_wdata, MAX_HEIGHT));
        end
        relemb_pkg::CFG_STRENGTH: begin
          bias_r <= cfg_wdata[8:1];
        end
        default: begin
        end
      endcase
    end
  end

  logic                 job_in_valid, job_in_ready;
  relemb_pkg::job_t     job_in, job_head;
  logic                 job_head_valid, job_pop;
  logic [JLW-1:0]       job_level;
  logic                 oq_push, oq_ready;
  relemb_pkg::out_word_t oq_data;
  logic [OLW-1:0]       oq_level;

  assign in_ready = job_in_ready;

  relemb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .job_ready (job_in_ready),
    .job_valid (job_in_valid),
    .job       (job_in),
    .frame_w   (frame_w_r),
    .frame_h   (frame_h_r)
  );

  relemb_queue #(
    .T     (relemb_pkg::job_t),
    .DEPTH (relemb_pkg::JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_in_valid),
    .push_ready (job_in_ready),
    .push_data  (job_in),
    .pop_valid  (job_head_valid),
    .pop_ready  (job_pop),
    .pop_data   (job_head),
    .level      (job_level)
  );

  relemb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_head_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .frame_w   (frame_w_r),
    .frame_h   (frame_h_r),
    .bias      (bias_r),
    .oq_level  (oq_level),
    .oq_ready  (oq_ready),
    .oq_push   (oq_push),
    .oq_data   (oq_data)
  );

  relemb_queue #(
    .T     (relemb_pkg::out_word_t),
    .DEPTH (relemb_pkg::OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (oq_push),
    .push_ready (oq_ready),
    .push_data  (oq_data),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data),
    .level      (oq_level)
  );

  a_job_level: assert property (@(posedge clk) disable iff (!rst_n)
    (job_level == '0) |-> !job_head_valid)
    else $error("job queue offered a word while empty");

endmodule

// ===== rtl/core/relemb_ram.sv =====
// ----------------------------------------------------------------------------
// relemb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module relemb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/relemb_queue.sv =====
// ----------------------------------------------------------------------------
// relemb_queue
// Short first-in first-out queue of words with a fill level output.
// ----------------------------------------------------------------------------
module relemb_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  T                           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output T                           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH+1);

  T                entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != LW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign level      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/relemb_front.sv =====
// ----------------------------------------------------------------------------
// relemb_front
// Tracks the raster position of incoming pixels and works out which interior
// positions each pixel completes as their offset pixel.
// ----------------------------------------------------------------------------
module relemb_front #(
  parameter int unsigned MAX_WIDTH  = relemb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = relemb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  relemb_pkg::in_word_t             in_data,
  input  logic                             job_ready,
  output logic                             job_valid,
  output relemb_pkg::job_t                 job,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  frame_h
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned POS_W = relemb_pkg::POS_W;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [1:0]    slot_r;
  logic [CW:0]   col_a, col_p1, w_e, col_nxt;
  logic [RW:0]   row_a, row_p1, h_e, row_nxt;
  logic [1:0]    slot_a, slot_nxt;
  logic          accept;

  assign accept    = in_valid && job_ready;
  assign job_valid = in_valid;
  assign w_e       = (CW+1)'(frame_w);
  assign h_e       = (RW+1)'(frame_h);

  // Position of the pixel now offered, after a frame start and after any
  // wrap left by a size that was reprogrammed smaller.
  always_comb begin
    col_a  = {1'b0, col_r};
    row_a  = {1'b0, row_r};
    slot_a = slot_r;
    if (in_data.frame_start) begin
      col_a  = '0;
      row_a  = '0;
      slot_a = '0;
    end
    if (col_a >= w_e) begin
      col_a  = '0;
      row_a  = row_a + 1'b1;
      slot_a = relemb_pkg::slot_inc(slot_a);
    end
    if (row_a >= h_e) begin
      row_a  = '0;
      slot_a = '0;
    end
  end

  assign col_p1 = col_a + 1'b1;
  assign row_p1 = row_a + 1'b1;

  // Centres that this pixel completes. Inside the frame it is the pixel two
  // up and two left; the last column and row also finish the second-last.
  always_comb begin
    job         = '0;
    job.px      = {in_data.red_in, in_data.green_in, in_data.blue_in};
    job.col     = POS_W'(col_a);
    job.wr_slot = slot_a;
    if (col_p1 < w_e) begin
      if (col_a >= (CW+1)'(3)) begin
        job.nx = 2'd1;
        job.x0 = POS_W'(col_a - (CW+1)'(2));
      end
    end else if (w_e >= (CW+1)'(4)) begin
      job.nx = 2'd2;
      job.x0 = POS_W'(w_e - (CW+1)'(3));
    end else begin
      job.nx = 2'd1;
      job.x0 = POS_W'(w_e - (CW+1)'(2));
    end
    if (row_p1 < h_e) begin
      if (row_a >= (RW+1)'(3)) begin
        job.ny      = 2'd1;
        job.y0      = POS_W'(row_a - (RW+1)'(2));
        job.y0_slot = relemb_pkg::slot_inc(slot_a);
      end
    end else if (h_e >= (RW+1)'(4)) begin
      job.ny      = 2'd2;
      job.y0      = POS_W'(h_e - (RW+1)'(3));
      job.y0_slot = relemb_pkg::slot_inc(slot_a);
    end else begin
      job.ny      = 2'd1;
      job.y0      = POS_W'(h_e - (RW+1)'(2));
      job.y0_slot = relemb_pkg::slot_inc(relemb_pkg::slot_inc(slot_a));
    end
  end

  always_comb begin
    col_nxt  = col_p1;
    row_nxt  = row_a;
    slot_nxt = slot_a;
    if (col_p1 >= w_e) begin
      col_nxt  = '0;
      row_nxt  = row_p1;
      slot_nxt = relemb_pkg::slot_inc(slot_a);
      if (row_p1 >= h_e) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt[CW-1:0];
      row_r  <= row_nxt[RW-1:0];
      slot_r <= slot_nxt;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("line slot left the range of three rows");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.frame_start) |=> (col_r == CW'(1) && row_r == '0 && slot_r == '0))
    else $error("frame start did not restart the raster position");

endmodule

// ===== rtl/core/relemb_back.sv =====
// ----------------------------------------------------------------------------
// relemb_back
// Owns the three-row line store. Writes each pixel, reads the centres that it
// completes one per cycle while the output queue has room; clamps each result.
// ----------------------------------------------------------------------------
module relemb_back #(
  parameter int unsigned MAX_WIDTH  = relemb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = relemb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             job_valid,
  input  relemb_pkg::job_t                                 job,
  output logic                                             job_pop,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                   frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                  frame_h,
  input  logic [relemb_pkg::CHAN_W-1:0]                    bias,
  input  logic [$clog2(relemb_pkg::OUT_QUEUE_DEPTH+1)-1:0] oq_level,
  input  logic                                             oq_ready,
  output logic                                             oq_push,
  output relemb_pkg::out_word_t                            oq_data
);

  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned ADDR_W = $clog2(3 * MAX_WIDTH);
  localparam int unsigned POS_W  = relemb_pkg::POS_W;
  localparam int unsigned OPW    = relemb_pkg::OUT_POS_W;
  localparam int unsigned PIX_W  = relemb_pkg::PIX_W;
  localparam int unsigned OLW    = $clog2(relemb_pkg::OUT_QUEUE_DEPTH+1);

  function automatic logic [ADDR_W-1:0] line_addr(logic [1:0] slot, logic [CW-1:0] x);
    logic [ADDR_W-1:0] base;
    case (slot)
      2'd1:    base = ADDR_W'(MAX_WIDTH);
      2'd2:    base = ADDR_W'(2 * MAX_WIDTH);
      default: base = '0;
    endcase
    return base + ADDR_W'(x);
  endfunction

  logic [1:0]        k_r, k_nxt;
  logic              rd_valid_r;
  logic [OPW-1:0]    s_col_r, s_row_r;
  logic [PIX_W-1:0]  s_offs_r;
  logic              s_last_r, s_fend_r;

  logic [2:0]        n_res;
  logic              i_sel, j_sel, room, issue, last_k;
  logic [POS_W-1:0]  x_cur, y_cur;
  logic [1:0]        y_slot;
  logic              fend;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  centre;

  // Results of one word go row first, then column.
  assign n_res  = 3'(job.nx) * 3'(job.ny);
  assign i_sel  = (job.nx == 2'd2) ? k_r[0] : 1'b0;
  assign j_sel  = (job.nx == 2'd2) ? k_r[1] : k_r[0];
  assign x_cur  = job.x0 + POS_W'(i_sel);
  assign y_cur  = job.y0 + POS_W'(j_sel);
  assign y_slot = j_sel ? relemb_pkg::slot_inc(job.y0_slot) : job.y0_slot;
  assign fend   = ({1'b0, x_cur} + (POS_W+1)'(2) == (POS_W+1)'(frame_w)) &&
                  ({1'b0, y_cur} + (POS_W+1)'(2) == (POS_W+1)'(frame_h));

  // A read is issued only if the output queue is sure to have room for its
  // result, counting the one still waiting on the store's read data.
  assign room   = ((OLW+1)'(oq_level) + (OLW+1)'(rd_valid_r)) <
                  (OLW+1)'(relemb_pkg::OUT_QUEUE_DEPTH);
  assign issue  = job_valid && ((n_res == '0) || room);
  assign last_k = (n_res == '0) || ({1'b0, k_r} == n_res - 3'd1);
  assign job_pop = issue && last_k;

  assign ram_we    = issue && (k_r == '0);
  assign ram_re    = issue && (n_res != '0);
  assign ram_waddr = line_addr(job.wr_slot, job.col[CW-1:0]);
  assign ram_raddr = line_addr(y_slot, x_cur[CW-1:0]);

  relemb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (3 * MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (job.px),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (centre)
  );

  assign k_nxt = last_k ? '0 : k_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        k_r <= k_nxt;
      end
      rd_valid_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s_col_r  <= x_cur[OPW-1:0];
      s_row_r  <= y_cur[OPW-1:0];
      s_offs_r <= job.px;
      s_last_r <= last_k;
      s_fend_r <= fend;
    end
  end

  assign oq_push = rd_valid_r;

  always_comb begin
    oq_data             = '0;
    oq_data.out_col     = s_col_r;
    oq_data.out_row     = s_row_r;
    oq_data.red_out     = relemb_pkg::relief_chan(centre[23:16], s_offs_r[23:16], bias);
    oq_data.green_out   = relemb_pkg::relief_chan(centre[15:8], s_offs_r[15:8], bias);
    oq_data.blue_out    = relemb_pkg::relief_chan(centre[7:0], s_offs_r[7:0], bias);
    oq_data.last_of_run = s_last_r;
    oq_data.frame_end   = s_fend_r;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> oq_ready)
    else $error("relief word arrived with the output queue full");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && n_res != '0) |-> ({1'b0, k_r} < n_res))
    else $error("result step ran past the results of the word");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line store read and write hit the same entry");

endmodule
